// ===== rtl/rau_pkg.sv =====
package rau_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int WIDE_WIDTH         = 64;
   localparam int FIELD_WIDTH        = 32;
   localparam int DEN_WIDTH          = 31;
   localparam int MODE_WIDTH         = 2;
   localparam int STATUS_WIDTH       = 2;

   typedef logic [MODE_WIDTH-1:0]   mode_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   localparam mode_type MODE_ADD = 2'd0;
   localparam mode_type MODE_SUB = 2'd1;
   localparam mode_type MODE_MUL = 2'd2;
   localparam mode_type MODE_DIV = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_ZERO_DEN = 2'd1;
   localparam status_type ST_DIV_ZERO = 2'd2;
   localparam status_type ST_OVERFLOW = 2'd3;

endpackage

// ===== rtl/rau_if.sv =====
interface rau_req_if;
   logic                                    valid;
   logic                                    ready;
   rau_pkg::mode_type                       mode;
   logic signed [rau_pkg::FIELD_WIDTH-1:0]  a_num;
   logic signed [rau_pkg::FIELD_WIDTH-1:0]  a_den;
   logic signed [rau_pkg::FIELD_WIDTH-1:0]  b_num;
   logic signed [rau_pkg::FIELD_WIDTH-1:0]  b_den;

   modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rau_pkg::FIELD_WIDTH-1:0]  res_num;
   logic [rau_pkg::DEN_WIDTH-1:0]           res_den;
   rau_pkg::status_type                     status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink (input valid, res_num, res_den, status, output ready);
endinterface

// ===== rtl/rational_arithmetic_unit_top.sv =====
// Rational arithmetic unit: takes two fractions and an operation (add, subtract, multiply,
// divide) and returns the result as a fully reduced fraction with a positive denominator,
// together with a status (ok, zero denominator, division by zero, overflow). A request is
// processed on its own: the input is not ready again until the result has been handed to the
// result register, which may still be waiting while the next request is taken. A request
// with a zero denominator or a division by zero goes straight to the output state. Otherwise
// both operands and, for add and subtract, the two denominators are reduced one after the
// other, then two or three products are formed, and the result is reduced. Every reduction
// runs a binary gcd (one subtract-and-shift step per cycle) and two restoring divisions of
// one quotient bit per cycle, DATA_WIDTH bits for the operands and 64 bits for the result. A
// zero numerator skips its reduction. All of this shares a single 64-bit subtractor.
module rational_arithmetic_unit_top #(
   parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rau_req_if.sink    req_ch,
   rau_rsp_if.source  rsp_ch
);

   localparam int WW  = rau_pkg::WIDE_WIDTH;
   localparam int FW  = rau_pkg::FIELD_WIDTH;
   localparam int DW  = rau_pkg::DEN_WIDTH;
   localparam int CW  = $clog2(WW + 1);
   localparam int PRE = WW - DATA_WIDTH;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_GCD   = 3'd2;
   localparam logic [2:0] S_DIVX  = 3'd3;
   localparam logic [2:0] S_DIVY  = 3'd4;
   localparam logic [2:0] S_STORE = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   localparam logic [1:0] PH_A   = 2'd0;
   localparam logic [1:0] PH_B   = 2'd1;
   localparam logic [1:0] PH_DEN = 2'd2;
   localparam logic [1:0] PH_RES = 2'd3;

   localparam logic [CW-1:0] CNT_OP  = CW'(DATA_WIDTH - 1);
   localparam logic [CW-1:0] CNT_RES = CW'(WW - 1);
   localparam logic [WW-1:0] ONE     = WW'(1);
   localparam logic [WW-1:0] LIM     = ONE << (DATA_WIDTH - 1);

   // Sign and magnitude of the low DATA_WIDTH bits read as two's complement.
   function automatic logic [DATA_WIDTH:0] split(input logic [FW-1:0] v);
      logic [DATA_WIDTH-1:0] m;
      m = v[DATA_WIDTH-1:0];
      if (m[DATA_WIDTH-1]) begin
         return {1'b1, ~m + 1'b1};
      end
      return {1'b0, m};
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   rau_pkg::mode_type     mode_ff, mode_in;
   logic                  a_neg_ff, a_neg_in, b_neg_ff, b_neg_in;
   logic [DATA_WIDTH-1:0] a_mag_ff, a_mag_in, a_den_ff, a_den_in;
   logic [DATA_WIDTH-1:0] b_mag_ff, b_mag_in, b_den_ff, b_den_in;
   logic [DATA_WIDTH-1:0] fa_ff, fa_in, fb_ff, fb_in;
   logic [WW-1:0]         prod_ff [3];
   logic [WW-1:0]         prod_in [3];
   logic [1:0]            mcnt_ff, mcnt_in;
   logic                  res_neg_ff, res_neg_in;
   logic [WW-1:0]         opx_ff, opx_in, opy_ff, opy_in;
   logic [WW-1:0]         u_ff, u_in, v_ff, v_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [WW-1:0]         rem_ff, rem_in, dq_ff, dq_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [WW-1:0]         qx_ff, qx_in, qy_ff, qy_in;
   logic [FW-1:0]         fin_num_ff, fin_num_in;
   logic [DW-1:0]         fin_den_ff, fin_den_in;
   rau_pkg::status_type   fin_st_ff, fin_st_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]         rsp_num_ff, rsp_num_in;
   logic [DW-1:0]         rsp_den_ff, rsp_den_in;
   rau_pkg::status_type   rsp_st_ff, rsp_st_in;

   // Shared subtractor, used by the gcd steps and the division steps.
   logic [WW-1:0]         sub_a, sub_b, rem_sh, neg_diff;
   logic [WW:0]           sub_r;
   logic                  borrow;

   logic [DATA_WIDTH:0]   an_s, ad_s, bn_s, bd_s;
   logic                  b_eff_neg, sum_neg;
   logic [WW-1:0]         sum_mag, sum_den, load_x, load_y;
   logic [DATA_WIDTH-1:0] mul_a, mul_b;
   logic [2*DATA_WIDTH-1:0] mul_p;
   logic                  add_like;
   logic [WW-1:0]         div_x_start, div_y_start, dq_step;
   logic [CW-1:0]         cnt_start;
   logic                  q_neg, fits;

   assign rem_sh   = {rem_ff[WW-2:0], dq_ff[WW-1]};
   assign sub_a    = (state_ff == S_GCD) ? u_ff : rem_sh;
   assign sub_b    = v_ff;
   assign sub_r    = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow   = sub_r[WW];
   assign neg_diff = {WW{1'b0}} - sub_r[WW-1:0];
   assign dq_step  = {dq_ff[WW-2:0], ~borrow};

   assign an_s = split(req_ch.a_num);
   assign ad_s = split(req_ch.a_den);
   assign bn_s = split(req_ch.b_num);
   assign bd_s = split(req_ch.b_den);

   assign add_like = (mode_ff == rau_pkg::MODE_ADD) || (mode_ff == rau_pkg::MODE_SUB);

   // Combine the products into the unreduced result.
   always_comb begin
      b_eff_neg = (mode_ff == rau_pkg::MODE_SUB) ? ~b_neg_ff : b_neg_ff;
      if (add_like) begin
         sum_den = prod_ff[2];
         if (a_neg_ff == b_eff_neg) begin
            sum_neg = a_neg_ff;
            sum_mag = prod_ff[0] + prod_ff[1];
         end else if (prod_ff[0] >= prod_ff[1]) begin
            sum_neg = a_neg_ff;
            sum_mag = prod_ff[0] - prod_ff[1];
         end else begin
            sum_neg = b_eff_neg;
            sum_mag = prod_ff[1] - prod_ff[0];
         end
      end else begin
         sum_neg = a_neg_ff ^ b_neg_ff;
         sum_mag = prod_ff[0];
         sum_den = prod_ff[1];
      end
   end

   always_comb begin
      unique case (phase_ff)
         PH_A: begin
            load_x = WW'(a_mag_ff);
            load_y = WW'(a_den_ff);
         end
         PH_B: begin
            load_x = WW'(b_mag_ff);
            load_y = WW'(b_den_ff);
         end
         PH_DEN: begin
            load_x = WW'(a_den_ff);
            load_y = WW'(b_den_ff);
         end
         PH_RES: begin
            load_x = sum_mag;
            load_y = sum_den;
         end
      endcase
   end

   // Operands of the one multiplier, by operation and product index.
   always_comb begin
      mul_a = a_mag_ff;
      mul_b = b_mag_ff;
      unique case (mode_ff)
         rau_pkg::MODE_ADD, rau_pkg::MODE_SUB: begin
            priority case (mcnt_ff)
               2'd0: begin
                  mul_a = a_mag_ff;
                  mul_b = fa_ff;
               end
               2'd1: begin
                  mul_a = b_mag_ff;
                  mul_b = fb_ff;
               end
               default: begin
                  mul_a = a_den_ff;
                  mul_b = fa_ff;
               end
            endcase
         end
         rau_pkg::MODE_MUL: begin
            mul_a = (mcnt_ff == 2'd0) ? a_mag_ff : a_den_ff;
            mul_b = (mcnt_ff == 2'd0) ? b_mag_ff : b_den_ff;
         end
         rau_pkg::MODE_DIV: begin
            mul_a = (mcnt_ff == 2'd0) ? a_mag_ff : a_den_ff;
            mul_b = (mcnt_ff == 2'd0) ? b_den_ff : b_mag_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // The divisions are by (v << k), so the dividend is shifted right by k first. Operand
   // dividends only need DATA_WIDTH quotient bits and are moved to the top of the word.
   always_comb begin
      if (phase_ff == PH_RES) begin
         div_x_start = opx_ff >> k_ff;
         div_y_start = opy_ff >> k_ff;
         cnt_start   = CNT_RES;
      end else begin
         div_x_start = (opx_ff >> k_ff) << PRE;
         div_y_start = (opy_ff >> k_ff) << PRE;
         cnt_start   = CNT_OP;
      end
   end

   assign q_neg = res_neg_ff && (qx_ff != {WW{1'b0}});
   assign fits  = (qy_ff <= LIM - ONE) && (q_neg ? (qx_ff <= LIM) : (qx_ff <= LIM - ONE));

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mode_in      = mode_ff;
      a_neg_in     = a_neg_ff;
      a_mag_in     = a_mag_ff;
      a_den_in     = a_den_ff;
      b_neg_in     = b_neg_ff;
      b_mag_in     = b_mag_ff;
      b_den_in     = b_den_ff;
      fa_in        = fa_ff;
      fb_in        = fb_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      res_neg_in   = res_neg_ff;
      opx_in       = opx_ff;
      opy_in       = opy_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      cnt_in       = cnt_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      fin_num_in   = fin_num_ff;
      fin_den_in   = fin_den_ff;
      fin_st_in    = fin_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_st_in    = rsp_st_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in    = req_ch.mode;
               fin_num_in = {FW{1'b0}};
               fin_den_in = {DW{1'b0}};
               if ((ad_s[DATA_WIDTH-1:0] == '0) || (bd_s[DATA_WIDTH-1:0] == '0)) begin
                  fin_st_in = rau_pkg::ST_ZERO_DEN;
                  state_in  = S_OUT;
               end else if ((req_ch.mode == rau_pkg::MODE_DIV) &&
                            (bn_s[DATA_WIDTH-1:0] == '0)) begin
                  fin_st_in = rau_pkg::ST_DIV_ZERO;
                  state_in  = S_OUT;
               end else begin
                  a_neg_in = an_s[DATA_WIDTH] ^ ad_s[DATA_WIDTH];
                  a_mag_in = an_s[DATA_WIDTH-1:0];
                  a_den_in = ad_s[DATA_WIDTH-1:0];
                  b_neg_in = bn_s[DATA_WIDTH] ^ bd_s[DATA_WIDTH];
                  b_mag_in = bn_s[DATA_WIDTH-1:0];
                  b_den_in = bd_s[DATA_WIDTH-1:0];
                  phase_in = PH_A;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            opx_in = load_x;
            opy_in = load_y;
            u_in   = load_x;
            v_in   = load_y;
            k_in   = {CW{1'b0}};
            if (phase_ff == PH_RES) begin
               res_neg_in = sum_neg;
            end
            if (load_x == {WW{1'b0}}) begin
               // A zero numerator reduces to 0/1 without a gcd.
               qx_in    = {WW{1'b0}};
               qy_in    = ONE;
               state_in = S_STORE;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (u_ff == {WW{1'b0}}) begin
               rem_in   = {WW{1'b0}};
               dq_in    = div_x_start;
               cnt_in   = cnt_start;
               state_in = S_DIVX;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!borrow) begin
               u_in = sub_r[WW-1:0] >> 1;
            end else begin
               v_in = neg_diff >> 1;
            end
         end
         S_DIVX, S_DIVY: begin
            rem_in = borrow ? rem_sh : sub_r[WW-1:0];
            dq_in  = dq_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == {CW{1'b0}}) begin
               if (state_ff == S_DIVX) begin
                  qx_in    = dq_step;
                  rem_in   = {WW{1'b0}};
                  dq_in    = div_y_start;
                  cnt_in   = cnt_start;
                  state_in = S_DIVY;
               end else begin
                  qy_in    = dq_step;
                  state_in = S_STORE;
               end
            end
         end
         S_STORE: begin
            unique case (phase_ff)
               PH_A: begin
                  a_mag_in = qx_ff[DATA_WIDTH-1:0];
                  a_den_in = qy_ff[DATA_WIDTH-1:0];
                  a_neg_in = a_neg_ff && (qx_ff != {WW{1'b0}});
                  phase_in = PH_B;
                  state_in = S_LOAD;
               end
               PH_B: begin
                  b_mag_in = qx_ff[DATA_WIDTH-1:0];
                  b_den_in = qy_ff[DATA_WIDTH-1:0];
                  b_neg_in = b_neg_ff && (qx_ff != {WW{1'b0}});
                  mcnt_in  = 2'd0;
                  if (add_like) begin
                     phase_in = PH_DEN;
                     state_in = S_LOAD;
                  end else begin
                     state_in = S_MUL;
                  end
               end
               PH_DEN: begin
                  // Reduced denominators give the cross factors directly.
                  fb_in    = qx_ff[DATA_WIDTH-1:0];
                  fa_in    = qy_ff[DATA_WIDTH-1:0];
                  mcnt_in  = 2'd0;
                  state_in = S_MUL;
               end
               PH_RES: begin
                  if (fits) begin
                     fin_num_in = q_neg ? ({FW{1'b0}} - qx_ff[FW-1:0]) : qx_ff[FW-1:0];
                     fin_den_in = qy_ff[DW-1:0];
                     fin_st_in  = rau_pkg::ST_OK;
                  end else begin
                     fin_num_in = {FW{1'b0}};
                     fin_den_in = {DW{1'b0}};
                     fin_st_in  = rau_pkg::ST_OVERFLOW;
                  end
                  state_in = S_OUT;
               end
            endcase
         end
         S_MUL: begin
            prod_in[mcnt_ff] = WW'(mul_p);
            if (mcnt_ff == (add_like ? 2'd2 : 2'd1)) begin
               phase_in = PH_RES;
               state_in = S_LOAD;
            end else begin
               mcnt_in = mcnt_ff + 1'b1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = fin_num_ff;
               rsp_den_in   = fin_den_ff;
               rsp_st_in    = fin_st_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_A;
         mode_ff      <= rau_pkg::MODE_ADD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_neg_ff   <= a_neg_in;
      a_mag_ff   <= a_mag_in;
      a_den_ff   <= a_den_in;
      b_neg_ff   <= b_neg_in;
      b_mag_ff   <= b_mag_in;
      b_den_ff   <= b_den_in;
      fa_ff      <= fa_in;
      fb_ff      <= fb_in;
      prod_ff    <= prod_in;
      mcnt_ff    <= mcnt_in;
      res_neg_ff <= res_neg_in;
      opx_ff     <= opx_in;
      opy_ff     <= opy_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      k_ff       <= k_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      cnt_ff     <= cnt_in;
      qx_ff      <= qx_in;
      qy_ff      <= qy_in;
      fin_num_ff <= fin_num_in;
      fin_den_ff <= fin_den_in;
      fin_st_ff  <= fin_st_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.res_num = rsp_num_ff;
   assign rsp_ch.res_den = rsp_den_ff;
   assign rsp_ch.status  = rsp_st_ff;

endmodule

// ===== rtl/rau_checker.sv =====
module rau_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [rau_pkg::FIELD_WIDTH-1:0]    res_num,
   input logic [rau_pkg::DEN_WIDTH-1:0]      res_den,
   input rau_pkg::status_type                status
);

   // Once a request is taken the unit is busy for at least the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready straight after an accepted request");

   a_error_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status != rau_pkg::ST_OK) |-> (res_num == '0) && (res_den == '0))
      else $error("error result with nonzero fraction");

   a_ok_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == rau_pkg::ST_OK) |-> (res_den != '0))
      else $error("ok result with zero denominator");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(res_num) && $stable(res_den) && $stable(status))
      else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .res_num   (rsp_ch.res_num),
   .res_den   (rsp_ch.res_den),
   .status    (rsp_ch.status)
);
